/* hw/rtl/brb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_pkg: shared definitions for the beacon range/bearing pipeline
// Field widths, CORDIC angle table, config register codes and the words
// that move between the pipeline sections.
// ----------------------------------------------------------------------------
package brb_pkg;

    // field widths
    localparam int FIELD_W = 16;               // positions, heading, config data
    localparam int DIFF_W  = FIELD_W + 1;      // position differences
    localparam int ANGLE_W = 17;               // relative angle
    localparam int SQ_W    = 32;               // squared lengths
    localparam int QUO_W   = 32;               // quotient of size^2 * 2^24 / dist^2
    localparam int ROOT_W  = QUO_W / 2;        // angular size
    localparam int NUM_SHIFT = 24;             // scale of the size numerator

    // iteration counts
    localparam int DIV_STEPS  = QUO_W;
    localparam int SQRT_STEPS = ROOT_W;

    // CORDIC datapath, angles in 2^-20 rad
    localparam int CORDIC_STEPS = 20;
    localparam int XY_PRESHIFT  = 14;
    localparam int XY_W         = 34;
    localparam int Z_W          = 23;
    localparam int Z_DROP       = 8;           // 2^-20 rad down to 2^-12 rad
    localparam logic signed [Z_W-1:0] Z_ROUND     = 23'sd128;
    localparam logic signed [Z_W-1:0] HALF_PI_Q20 = 23'sd1647099;
    localparam logic signed [Z_W-1:0] ATAN_Q20 [CORDIC_STEPS] = '{
        23'sd823550, 23'sd486170, 23'sd256879, 23'sd130396, 23'sd65451,
        23'sd32757,  23'sd16383,  23'sd8192,   23'sd4096,   23'sd2048,
        23'sd1024,   23'sd512,    23'sd256,    23'sd128,    23'sd64,
        23'sd32,     23'sd16,     23'sd8,      23'sd4,      23'sd2
    };

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FIELD_W;
    localparam logic [CFG_IDX_W-1:0] REG_DETECT_LIMIT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REFLECTOR_SIZE = 1'b1;
    localparam logic [FIELD_W-1:0]   DETECT_LIMIT_RST   = 16'd1536;
    localparam logic [FIELD_W-1:0]   REFLECTOR_SIZE_RST = 16'd82;

    localparam logic [ROOT_W-1:0] SIZE_MAX = '1;

    // range data carried alongside the CORDIC
    typedef struct packed {
        logic            sat;       // size saturates (also zero distance)
        logic [SQ_W-1:0] dist_sq;
        logic [SQ_W-1:0] size_sq;
    } range_info_t;

    // word leaving the front section
    typedef struct packed {
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [FIELD_W-1:0] heading;
        range_info_t               info;
    } front_word_t;

    // angle data carried alongside the divider and square root
    typedef struct packed {
        logic                      sat;
        logic signed [ANGLE_W-1:0] rel_angle;
    } angle_info_t;

endpackage

/* hw/rtl/brb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_if: valid/ready channels of the beacon range/bearing block
// brb_in_if carries one position word, brb_out_if one result word.
// ----------------------------------------------------------------------------
interface brb_in_if import brb_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] robot_x;
    logic signed [FIELD_W-1:0] robot_y;
    logic signed [FIELD_W-1:0] heading;
    logic signed [FIELD_W-1:0] target_x;
    logic signed [FIELD_W-1:0] target_y;

    modport source (output valid, robot_x, robot_y, heading, target_x, target_y,
                    input ready);
    modport sink   (input valid, robot_x, robot_y, heading, target_x, target_y,
                    output ready);
endinterface

interface brb_out_if import brb_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] rel_angle;
    logic [ROOT_W-1:0]         angular_size;

    modport source (output valid, rel_angle, angular_size, input ready);
    modport sink   (input valid, rel_angle, angular_size, output ready);
endinterface

/* hw/rtl/brb_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_front: difference vector, squared lengths and detection test
// Three stages: subtract, square, sum and compare. Words outside the
// detection limit are dropped at the third stage.
// ----------------------------------------------------------------------------
module brb_front import brb_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    brb_in_if.sink             sample,
    input  logic [FIELD_W-1:0] detect_limit,
    input  logic [FIELD_W-1:0] reflector_size,
    output logic               out_valid,
    output front_word_t        out_word
);

    logic s1_vld_reg, s2_vld_reg, s3_vld_reg;

    logic signed [DIFF_W-1:0]  s1_dx_reg, s1_dy_reg, s1_dx_next, s1_dy_next;
    logic signed [FIELD_W-1:0] s1_head_reg;

    logic signed [2*DIFF_W-1:0] dx_prod, dy_prod;
    logic [SQ_W-1:0] lim_sq, size_sq;
    logic [SQ_W-1:0] s2_dx_sq_reg, s2_dy_sq_reg, s2_lim_sq_reg, s2_size_sq_reg;
    logic signed [DIFF_W-1:0]  s2_dx_reg, s2_dy_reg;
    logic signed [FIELD_W-1:0] s2_head_reg;

    logic [SQ_W:0] dist_full;
    logic          detect, sat;
    front_word_t   s3_word_reg, s3_word_next;

    assign sample.ready = adv;

    // stage 1: difference vector
    assign s1_dx_next = {sample.target_x[FIELD_W-1], sample.target_x}
                      - {sample.robot_x[FIELD_W-1], sample.robot_x};
    assign s1_dy_next = {sample.target_y[FIELD_W-1], sample.target_y}
                      - {sample.robot_y[FIELD_W-1], sample.robot_y};

    // stage 2: squares; the user keeps config stable for words in flight
    assign dx_prod = s1_dx_reg * s1_dx_reg;
    assign dy_prod = s1_dy_reg * s1_dy_reg;
    assign lim_sq  = SQ_W'(detect_limit) * SQ_W'(detect_limit);
    assign size_sq = SQ_W'(reflector_size) * SQ_W'(reflector_size);

    // stage 3: squared distance, detection and saturation tests
    assign dist_full = {1'b0, s2_dx_sq_reg} + {1'b0, s2_dy_sq_reg};
    assign detect    = dist_full < {1'b0, s2_lim_sq_reg};
    // quotient reaches 2^32 when size^2 * 2^24 / 2^32 >= dist^2
    assign sat       = {1'b0, s2_size_sq_reg >> (QUO_W - NUM_SHIFT)} >= dist_full;

    always_comb
    begin
        s3_word_next.dx           = s2_dx_reg;
        s3_word_next.dy           = s2_dy_reg;
        s3_word_next.heading      = s2_head_reg;
        s3_word_next.info.sat     = sat;
        s3_word_next.info.dist_sq = dist_full[SQ_W-1:0];
        s3_word_next.info.size_sq = s2_size_sq_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= sample.valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg & detect;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_dx_reg      <= s1_dx_next;
            s1_dy_reg      <= s1_dy_next;
            s1_head_reg    <= sample.heading;
            s2_dx_sq_reg   <= dx_prod[SQ_W-1:0];
            s2_dy_sq_reg   <= dy_prod[SQ_W-1:0];
            s2_lim_sq_reg  <= lim_sq;
            s2_size_sq_reg <= size_sq;
            s2_dx_reg      <= s1_dx_reg;
            s2_dy_reg      <= s1_dy_reg;
            s2_head_reg    <= s1_head_reg;
            s3_word_reg    <= s3_word_next;
        end
    end

    assign out_valid = s3_vld_reg;
    assign out_word  = s3_word_reg;

endmodule

/* hw/rtl/brb_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_cordic: pipelined vectoring CORDIC for the bearing
// Quadrant pre-rotation stage, one stage per micro-rotation, then a stage
// that rounds to 2^-12 rad and subtracts the heading.
// ----------------------------------------------------------------------------
module brb_cordic import brb_pkg::*; #(
    parameter int SB_W = $bits(range_info_t)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  logic signed [DIFF_W-1:0]  in_dx,
    input  logic signed [DIFF_W-1:0]  in_dy,
    input  logic signed [FIELD_W-1:0] in_heading,
    input  logic [SB_W-1:0]           in_sb,
    output logic                      out_valid,
    output logic signed [ANGLE_W-1:0] out_angle,
    output logic [SB_W-1:0]           out_sb
);

    localparam int PAD_W = XY_W - DIFF_W - XY_PRESHIFT;

    // stage 0 is the pre-rotation, stage k+1 follows micro-rotation k
    logic [CORDIC_STEPS:0]     vld_reg;
    logic [CORDIC_STEPS:0]     zero_reg;
    logic signed [XY_W-1:0]    x_reg    [CORDIC_STEPS+1];
    logic signed [XY_W-1:0]    y_reg    [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]     z_reg    [CORDIC_STEPS+1];
    logic signed [FIELD_W-1:0] head_reg [CORDIC_STEPS+1];
    logic [SB_W-1:0]           sb_reg   [CORDIC_STEPS+1];

    logic signed [XY_W-1:0] x_next [CORDIC_STEPS];
    logic signed [XY_W-1:0] y_next [CORDIC_STEPS];
    logic signed [Z_W-1:0]  z_next [CORDIC_STEPS];

    logic signed [XY_W-1:0] x0, y0, px, py;
    logic signed [Z_W-1:0]  pz;
    logic                   zero_in;

    logic signed [Z_W-1:0]     z_rnd, bearing;
    logic signed [ANGLE_W-1:0] head_ext, angle_next;
    logic                      fin_vld_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic [SB_W-1:0]           fin_sb_reg;

    // pre-rotation into the right half plane
    always_comb
    begin
        x0      = {{PAD_W{in_dx[DIFF_W-1]}}, in_dx, {XY_PRESHIFT{1'b0}}};
        y0      = {{PAD_W{in_dy[DIFF_W-1]}}, in_dy, {XY_PRESHIFT{1'b0}}};
        zero_in = (in_dx == '0) && (in_dy == '0);
        px      = x0;
        py      = y0;
        pz      = '0;
        if (in_dx[DIFF_W-1])
        begin
            if (!in_dy[DIFF_W-1])
            begin
                px = y0;
                py = -x0;
                pz = HALF_PI_Q20;
            end
            else
            begin
                px = -y0;
                py = x0;
                pz = -HALF_PI_Q20;
            end
        end
    end

    // micro-rotations, driving y toward zero
    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_step
        assign x_next[k] = y_reg[k][XY_W-1] ? x_reg[k] - (y_reg[k] >>> k)
                                            : x_reg[k] + (y_reg[k] >>> k);
        assign y_next[k] = y_reg[k][XY_W-1] ? y_reg[k] + (x_reg[k] >>> k)
                                            : y_reg[k] - (x_reg[k] >>> k);
        assign z_next[k] = y_reg[k][XY_W-1] ? z_reg[k] - ATAN_Q20[k]
                                            : z_reg[k] + ATAN_Q20[k];
    end

    // round to 2^-12 rad, remove heading; zero vector has bearing 0
    assign z_rnd      = z_reg[CORDIC_STEPS] + Z_ROUND;
    assign bearing    = z_rnd >>> Z_DROP;
    assign head_ext   = {head_reg[CORDIC_STEPS][FIELD_W-1], head_reg[CORDIC_STEPS]};
    assign angle_next = zero_reg[CORDIC_STEPS] ? ANGLE_W'(0) - head_ext
                                               : bearing[ANGLE_W-1:0] - head_ext;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            fin_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[CORDIC_STEPS-1:0], in_valid};
            fin_vld_reg <= vld_reg[CORDIC_STEPS];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0]    <= px;
            y_reg[0]    <= py;
            z_reg[0]    <= pz;
            zero_reg[0] <= zero_in;
            head_reg[0] <= in_heading;
            sb_reg[0]   <= in_sb;
            for (int k = 0; k < CORDIC_STEPS; k++)
            begin
                x_reg[k+1]    <= x_next[k];
                y_reg[k+1]    <= y_next[k];
                z_reg[k+1]    <= z_next[k];
                zero_reg[k+1] <= zero_reg[k];
                head_reg[k+1] <= head_reg[k];
                sb_reg[k+1]   <= sb_reg[k];
            end
            angle_reg  <= angle_next;
            fin_sb_reg <= sb_reg[CORDIC_STEPS];
        end
    end

    assign out_valid = fin_vld_reg;
    assign out_angle = angle_reg;
    assign out_sb    = fin_sb_reg;

    // a nonzero vector ends on the positive x axis
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[CORDIC_STEPS] && !zero_reg[CORDIC_STEPS] |-> x_reg[CORDIC_STEPS] > 0)
        else $error("cordic x not positive after last rotation");

endmodule

/* hw/rtl/brb_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_div: pipelined restoring divider, one quotient bit per stage
// The low dividend bits shift out of the top of lq while quotient bits
// shift in at the bottom.
// ----------------------------------------------------------------------------
module brb_div import brb_pkg::*; #(
    parameter int SB_W = $bits(angle_info_t)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [QUO_W-1:0] in_rem,    // upper dividend, below in_den
    input  logic [QUO_W-1:0] in_den,
    input  logic [QUO_W-1:0] in_lq,     // lower dividend bits
    input  logic [SB_W-1:0]  in_sb,
    output logic             out_valid,
    output logic [QUO_W-1:0] out_quo,
    output logic [SB_W-1:0]  out_sb
);

    logic [DIV_STEPS-1:0] vld_reg;
    logic [QUO_W-1:0]     rem_reg [DIV_STEPS];
    logic [QUO_W-1:0]     den_reg [DIV_STEPS];
    logic [QUO_W-1:0]     lq_reg  [DIV_STEPS];
    logic [SB_W-1:0]      sb_reg  [DIV_STEPS];

    logic [QUO_W-1:0] rem_cur  [DIV_STEPS];
    logic [QUO_W-1:0] den_cur  [DIV_STEPS];
    logic [QUO_W-1:0] lq_cur   [DIV_STEPS];
    logic [SB_W-1:0]  sb_cur   [DIV_STEPS];
    logic [QUO_W:0]   trial    [DIV_STEPS];
    logic [QUO_W:0]   diff     [DIV_STEPS];
    logic             ge       [DIV_STEPS];
    logic [QUO_W-1:0] rem_next [DIV_STEPS];
    logic [QUO_W-1:0] lq_next  [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        if (k == 0)
        begin : g_first
            assign rem_cur[k] = in_rem;
            assign den_cur[k] = in_den;
            assign lq_cur[k]  = in_lq;
            assign sb_cur[k]  = in_sb;
        end
        else
        begin : g_rest
            assign rem_cur[k] = rem_reg[k-1];
            assign den_cur[k] = den_reg[k-1];
            assign lq_cur[k]  = lq_reg[k-1];
            assign sb_cur[k]  = sb_reg[k-1];
        end

        // bring down one dividend bit, subtract when it fits
        assign trial[k]    = {rem_cur[k], lq_cur[k][QUO_W-1]};
        assign diff[k]     = trial[k] - {1'b0, den_cur[k]};
        assign ge[k]       = trial[k] >= {1'b0, den_cur[k]};
        assign rem_next[k] = ge[k] ? diff[k][QUO_W-1:0] : trial[k][QUO_W-1:0];
        assign lq_next[k]  = {lq_cur[k][QUO_W-2:0], ge[k]};
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DIV_STEPS-2:0], in_valid};
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_cur[k];
                lq_reg[k]  <= lq_next[k];
                sb_reg[k]  <= sb_cur[k];
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign out_quo   = lq_reg[DIV_STEPS-1];
    assign out_sb    = sb_reg[DIV_STEPS-1];

endmodule

/* hw/rtl/brb_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_sqrt: pipelined digit-by-digit integer square root
// Two radicand bits enter each stage and one root bit leaves it.
// ----------------------------------------------------------------------------
module brb_sqrt import brb_pkg::*; #(
    parameter int SB_W = $bits(angle_info_t)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [QUO_W-1:0]  in_rad,
    input  logic [SB_W-1:0]   in_sb,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output logic [SB_W-1:0]   out_sb
);

    localparam int REM_W = ROOT_W + 2;
    localparam int TRY_W = REM_W + 2;

    logic [SQRT_STEPS-1:0] vld_reg;
    logic [REM_W-1:0]      rem_reg  [SQRT_STEPS];
    logic [QUO_W-1:0]      rad_reg  [SQRT_STEPS];
    logic [ROOT_W-1:0]     root_reg [SQRT_STEPS];
    logic [SB_W-1:0]       sb_reg   [SQRT_STEPS];

    logic [REM_W-1:0]  rem_cur   [SQRT_STEPS];
    logic [QUO_W-1:0]  rad_cur   [SQRT_STEPS];
    logic [ROOT_W-1:0] root_cur  [SQRT_STEPS];
    logic [SB_W-1:0]   sb_cur    [SQRT_STEPS];
    logic [TRY_W-1:0]  part      [SQRT_STEPS];
    logic [TRY_W-1:0]  test      [SQRT_STEPS];
    logic [TRY_W-1:0]  diff      [SQRT_STEPS];
    logic              ge        [SQRT_STEPS];
    logic [REM_W-1:0]  rem_next  [SQRT_STEPS];
    logic [ROOT_W-1:0] root_next [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        if (k == 0)
        begin : g_first
            assign rem_cur[k]  = '0;
            assign rad_cur[k]  = in_rad;
            assign root_cur[k] = '0;
            assign sb_cur[k]   = in_sb;
        end
        else
        begin : g_rest
            assign rem_cur[k]  = rem_reg[k-1];
            assign rad_cur[k]  = rad_reg[k-1];
            assign root_cur[k] = root_reg[k-1];
            assign sb_cur[k]   = sb_reg[k-1];
        end

        // partial remainder with next two bits, trial 4*root + 1
        assign part[k]      = {rem_cur[k], rad_cur[k][QUO_W-1 -: 2]};
        assign test[k]      = {2'b00, root_cur[k], 2'b01};
        assign diff[k]      = part[k] - test[k];
        assign ge[k]        = part[k] >= test[k];
        assign rem_next[k]  = ge[k] ? diff[k][REM_W-1:0] : part[k][REM_W-1:0];
        assign root_next[k] = {root_cur[k][ROOT_W-2:0], ge[k]};
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[SQRT_STEPS-2:0], in_valid};
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                rad_reg[k]  <= {rad_cur[k][QUO_W-3:0], 2'b00};
                root_reg[k] <= root_next[k];
                sb_reg[k]   <= sb_cur[k];
            end
        end
    end

    assign out_valid = vld_reg[SQRT_STEPS-1];
    assign out_root  = root_reg[SQRT_STEPS-1];
    assign out_sb    = sb_reg[SQRT_STEPS-1];

    // final remainder q - root^2 never exceeds 2*root
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[SQRT_STEPS-1] |->
            rem_reg[SQRT_STEPS-1] <= {1'b0, root_reg[SQRT_STEPS-1], 1'b0})
        else $error("sqrt remainder out of range");

endmodule

/* hw/rtl/beacon_range_bearing.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beacon_range_bearing: relative bearing and angular size of a reflector
// Sections in order: front, CORDIC, divider, square root, output register.
// Throughput: one word per cycle; a held result word stalls the whole pipe.
// Words outside the detection limit leave no result.
// Reset: valid bits clear; detect_limit = 1536, reflector_size = 82.
// ----------------------------------------------------------------------------
module beacon_range_bearing import brb_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    brb_in_if.sink                sample,
    brb_out_if.source             result
);

    localparam int RANGE_SB_W = $bits(range_info_t);
    localparam int ANGLE_SB_W = $bits(angle_info_t);

    logic [FIELD_W-1:0] detect_limit_reg, reflector_size_reg;
    logic               adv;

    logic              fe_valid;
    front_word_t       fe_word;

    logic                      cd_valid;
    logic signed [ANGLE_W-1:0] cd_angle;
    logic [RANGE_SB_W-1:0]     cd_sb;
    range_info_t               cd_info;
    angle_info_t               cd_ang;

    logic                  dv_valid;
    logic [QUO_W-1:0]      dv_quo;
    logic [ANGLE_SB_W-1:0] dv_sb;

    logic                  sq_valid;
    logic [ROOT_W-1:0]     sq_root;
    logic [ANGLE_SB_W-1:0] sq_sb;
    angle_info_t           sq_info;

    logic                      out_vld_reg;
    logic signed [ANGLE_W-1:0] rel_angle_reg;
    logic [ROOT_W-1:0]         angular_size_reg, angular_size_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detect_limit_reg   <= DETECT_LIMIT_RST;
            reflector_size_reg <= REFLECTOR_SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DETECT_LIMIT:   detect_limit_reg   <= cfg_data;
                REG_REFLECTOR_SIZE: reflector_size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipe moves unless a result word is held
    assign adv = !out_vld_reg || result.ready;

    brb_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .sample         (sample),
        .detect_limit   (detect_limit_reg),
        .reflector_size (reflector_size_reg),
        .out_valid      (fe_valid),
        .out_word       (fe_word)
    );

    brb_cordic #(.SB_W(RANGE_SB_W)) u_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (fe_valid),
        .in_dx      (fe_word.dx),
        .in_dy      (fe_word.dy),
        .in_heading (fe_word.heading),
        .in_sb      (fe_word.info),
        .out_valid  (cd_valid),
        .out_angle  (cd_angle),
        .out_sb     (cd_sb)
    );

    assign cd_info          = range_info_t'(cd_sb);
    assign cd_ang.sat       = cd_info.sat;
    assign cd_ang.rel_angle = cd_angle;

    // dividend = size^2 * 2^NUM_SHIFT, split into upper and lower words
    brb_div #(.SB_W(ANGLE_SB_W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (cd_valid),
        .in_rem    (cd_info.size_sq >> (QUO_W - NUM_SHIFT)),
        .in_den    (cd_info.dist_sq),
        .in_lq     (cd_info.size_sq << NUM_SHIFT),
        .in_sb     (cd_ang),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_sb    (dv_sb)
    );

    brb_sqrt #(.SB_W(ANGLE_SB_W)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (dv_valid),
        .in_rad    (dv_quo),
        .in_sb     (dv_sb),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_sb    (sq_sb)
    );

    assign sq_info           = angle_info_t'(sq_sb);
    assign angular_size_next = sq_info.sat ? SIZE_MAX : sq_root;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rel_angle_reg    <= sq_info.rel_angle;
            angular_size_reg <= angular_size_next;
        end
    end

    assign result.valid        = out_vld_reg;
    assign result.rel_angle    = rel_angle_reg;
    assign result.angular_size = angular_size_reg;

    // a held result word blocks intake
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !sample.ready)
        else $error("input taken while result word held");

    // a result word only appears from a valid square-root stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(sq_valid && adv))
        else $error("result word without a pipeline word behind it");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for beacon_range_bearing
// Drives position words through the valid/ready input channel and predicts
// the relative bearing and angular size of each word inside the detection
// limit with a bit-exact integer CORDIC and integer square root. Result words
// are compared field by field, in order, against the queue of predicted
// sightings. A directed table covers extremes and the corner cases, then
// random words run under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import brb_pkg::*;

    localparam int PIPE_LATENCY  = 73;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_WORDS   = 115;
    localparam longint HALF_PI_FIX = 1647099;   // pi/2 in 2^-20 rad

    typedef struct packed {
        logic signed [FIELD_W-1:0] robot_x;
        logic signed [FIELD_W-1:0] robot_y;
        logic signed [FIELD_W-1:0] heading;
        logic signed [FIELD_W-1:0] target_x;
        logic signed [FIELD_W-1:0] target_y;
    } position_word_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] rel_angle;
        logic [ROOT_W-1:0]         angular_size;
    } sighting_t;

    // one directed row: register setting, position word, typed expectation
    typedef struct packed {
        logic [FIELD_W-1:0]        limit;
        logic [FIELD_W-1:0]        refl;
        logic signed [FIELD_W-1:0] rx;
        logic signed [FIELD_W-1:0] ry;
        logic signed [FIELD_W-1:0] hd;
        logic signed [FIELD_W-1:0] tx;
        logic signed [FIELD_W-1:0] ty;
        logic                      typed;
        logic                      hit;
        logic signed [ANGLE_W-1:0] angle;
        logic [ROOT_W-1:0]         size;
    } directed_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    brb_in_if  in_ch ();
    brb_out_if out_ch ();

    beacon_range_bearing dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (in_ch),
        .result    (out_ch)
    );

    // arctangent steps, 2^-20 rad
    longint cordic_atan [CORDIC_STEPS] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
        1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
    };

    // limit, reflector, robot x/y, heading, target x/y, typed, hit, angle, size
    directed_row_t directed_tab [DIRECTED_ROWS] = '{
        // zero distance, heading extremes and beyond
        '{1536, 82,      0,      0,      0,      0,      0, 1, 1,      0, 65535},
        '{1536, 82,  12345,  -2222,  25736,  12345,  -2222, 1, 1, -25736, 65535},
        '{1536, 82, -32768, -32768, -25736, -32768, -32768, 1, 1,  25736, 65535},
        '{1536, 82,  32767,  32767, -32768,  32767,  32767, 1, 1,  32768, 65535},
        '{1536, 82,      0,      0,  32767,      0,      0, 1, 1, -32767, 65535},
        // far apart, and exactly at the limit: no word
        '{1536, 82, -32768, -32768,      0,  32767,  32767, 1, 0,      0,     0},
        '{1536, 82,  32767,  32767,      0, -32768, -32768, 1, 0,      0,     0},
        '{1536, 82,      0,      0,      0,   1536,      0, 1, 0,      0,     0},
        '{1536, 82,      0,      0,      0,      0,  -1536, 1, 0,      0,     0},
        // just inside the limit, all four axes and the quadrant turns
        '{1536, 82,      0,      0,      0,   1535,      0, 0, 0,      0,     0},
        '{1536, 82,    100,    100,      0,  -1435,    100, 0, 0,      0,     0},
        '{1536, 82,      0,      0,   1000,      0,   1535, 0, 0,      0,     0},
        '{1536, 82,      0,      0,  -1000,      0,  -1535, 0, 0,      0,     0},
        '{1536, 82,    500,   -500,      0,   -500,  -1500, 0, 0,      0,     0},
        '{1536, 82,      0,      0,      0,      1,      0, 0, 0,      0,     0},
        '{1536, 82,  32767, -32768,      0,  32000, -32000, 0, 0,      0,     0},
        '{1536, 82,     -1,     -1,      0,      0,      0, 0, 0,      0,     0},
        // zero detection limit: nothing, not even at zero distance
        '{   0, 82,      0,      0,      0,      0,      0, 1, 0,      0,     0},
        '{   0, 82,      5,      5,      0,      6,      6, 1, 0,      0,     0},
        // zero reflector size
        '{1536,  0,      0,      0,      0,    300,    400, 0, 0,      0,     0},
        '{1536,  0,      0,      0,      0,      0,      0, 1, 1,      0, 65535},
        // widest registers
        '{65535, 65535, -32768, -32768,  0,  32767,  32767, 1, 0,      0,     0},
        '{65535, 65535, -32768,      0,  0,  32766,      0, 0, 0,      0,     0},
        '{65535, 65535,      0,      0, -20000,  0,      1, 0, 0,      0,     0},
        // smallest nonzero limit
        '{   1, 65535,      7,      7,      0,      7,      7, 1, 1,      0, 65535}
    };

    sighting_t          pending_sightings [$];
    logic [FIELD_W-1:0] cur_limit;
    logic [FIELD_W-1:0] cur_reflector;
    int                 in_idle_pct;
    int                 out_idle_pct;
    int                 fail_count = 0;
    int                 cycle_count = 0;

    // integer square root, floor
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // vectoring CORDIC, result in 2^-12 rad
    function automatic longint bearing_fix(input longint dx, input longint dy);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint t;
        int     i;
        if (dx == 0 && dy == 0)
            return 0;
        x = dx * 16384;
        y = dy * 16384;
        z = 0;
        // left half plane: turn by a quarter first
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = HALF_PI_FIX;
            end
            else
            begin
                x = -y;
                y = t;
                z = -HALF_PI_FIX;
            end
        end
        for (i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + cordic_atan[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - cordic_atan[i];
            end
        end
        return (z + 128) >>> 8;
    endfunction

    // returns 1 when the target is inside the detection limit
    function automatic bit predict_sighting(input position_word_t w, output sighting_t s_out);
        longint          dx;
        longint          dy;
        longint          dist_sq;
        longint          limit_sq;
        longint unsigned numer;
        longint unsigned size;
        longint          angle;
        s_out    = '0;
        dx       = longint'(w.target_x) - longint'(w.robot_x);
        dy       = longint'(w.target_y) - longint'(w.robot_y);
        dist_sq  = dx * dx + dy * dy;
        limit_sq = longint'(cur_limit) * longint'(cur_limit);
        if (dist_sq >= limit_sq)
            return 1'b0;
        if (dist_sq == 0)
            size = 65535;
        else
        begin
            numer = (longint'(cur_reflector) * longint'(cur_reflector)) << NUM_SHIFT;
            size  = int_sqrt(numer / longint'(dist_sq));
            if (size > 65535)
                size = 65535;
        end
        angle              = bearing_fix(dx, dy) - longint'(w.heading);
        s_out.rel_angle    = angle[ANGLE_W-1:0];
        s_out.angular_size = size[ROOT_W-1:0];
        return 1'b1;
    endfunction

    // random word: mostly targets near the robot, some far, some coincident
    function automatic position_word_t random_word();
        position_word_t w;
        int             kind;
        int             span;
        int             ox;
        int             oy;
        kind       = $urandom_range(0, 99);
        w.robot_x  = FIELD_W'($urandom);
        w.robot_y  = FIELD_W'($urandom);
        if ($urandom_range(0, 99) < 70)
            w.heading = FIELD_W'(int'($urandom_range(0, 51472)) - 25736);
        else
            w.heading = FIELD_W'($urandom);
        span = (cur_limit == 0) ? 2 : int'(cur_limit);
        ox   = int'($urandom_range(0, 2 * span)) - span;
        oy   = int'($urandom_range(0, 2 * span)) - span;
        if (kind < 10)
        begin
            w.target_x = w.robot_x;
            w.target_y = w.robot_y;
        end
        else if (kind < 75)
        begin
            w.target_x = FIELD_W'(w.robot_x + ox);
            w.target_y = FIELD_W'(w.robot_y + oy);
        end
        else
        begin
            w.target_x = FIELD_W'($urandom);
            w.target_y = FIELD_W'($urandom);
        end
        return w;
    endfunction

    // send one position word, queue what it should produce
    task automatic send_word(input position_word_t w, input bit typed,
                             input bit typed_hit, input sighting_t typed_exp);
        bit        hit;
        sighting_t want;
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.robot_x  <= w.robot_x;
        in_ch.robot_y  <= w.robot_y;
        in_ch.heading  <= w.heading;
        in_ch.target_x <= w.target_x;
        in_ch.target_y <= w.target_y;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (typed)
        begin
            hit  = typed_hit;
            want = typed_exp;
        end
        else
            hit = predict_sighting(w, want);
        if (hit)
            pending_sightings.push_back(want);
    endtask

    // write both registers once the pipe is empty
    task automatic apply_limits(input logic [FIELD_W-1:0] limit,
                                input logic [FIELD_W-1:0] refl);
        in_ch.valid <= 1'b0;
        while (pending_sightings.size() != 0)
            @(posedge clk);
        // words outside the limit may still be in flight
        repeat (PIPE_LATENCY + 8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DETECT_LIMIT;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_index <= REG_REFLECTOR_SIZE;
        cfg_data  <= refl;
        @(posedge clk);
        cfg_we        <= 1'b0;
        cur_limit     = limit;
        cur_reflector = refl;
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            0:
            begin
                in_idle_pct  = 22;
                out_idle_pct = 47;
            end
            1:
            begin
                in_idle_pct  = 47;
                out_idle_pct = 22;
            end
            default:
            begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
        endcase
    endtask

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge clk)
        out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);

    // compare each result word with the oldest predicted sighting
    always @(posedge clk)
    begin : check_results
        sighting_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_sightings.size() == 0)
            begin
                $error("unexpected word: rel_angle %0d angular_size %0d",
                       out_ch.rel_angle, out_ch.angular_size);
                fail_count++;
            end
            else
            begin
                want = pending_sightings.pop_front();
                if (out_ch.rel_angle !== want.rel_angle)
                begin
                    $error("rel_angle: expected %0d, got %0d",
                           want.rel_angle, out_ch.rel_angle);
                    fail_count++;
                end
                if (out_ch.angular_size !== want.angular_size)
                begin
                    $error("angular_size: expected %0d, got %0d",
                           want.angular_size, out_ch.angular_size);
                    fail_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        directed_row_t  row;
        position_word_t w;
        sighting_t      typed_exp;
        int             r;
        int             p;
        int             n;
        logic [FIELD_W-1:0] limit;
        logic [FIELD_W-1:0] refl;

        cur_limit      = DETECT_LIMIT_RST;
        cur_reflector  = REFLECTOR_SIZE_RST;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_DETECT_LIMIT;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.robot_x  = '0;
        in_ch.robot_y  = '0;
        in_ch.heading  = '0;
        in_ch.target_x = '0;
        in_ch.target_y = '0;
        set_idle_mode(0);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, first rows run on the reset values
        for (r = 0; r < DIRECTED_ROWS; r++)
        begin
            row = directed_tab[r];
            if (row.limit != cur_limit || row.refl != cur_reflector)
                apply_limits(row.limit, row.refl);
            w.robot_x  = row.rx;
            w.robot_y  = row.ry;
            w.heading  = row.hd;
            w.target_x = row.tx;
            w.target_y = row.ty;
            typed_exp.rel_angle    = row.angle;
            typed_exp.angular_size = row.size;
            send_word(w, row.typed, row.hit, typed_exp);
        end

        // random phases: idle pattern changes every two phases
        typed_exp = '0;
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    limit = DETECT_LIMIT_RST;
                    refl  = REFLECTOR_SIZE_RST;
                end
                1:
                begin
                    limit = 16'hFFFF;
                    refl  = 16'hFFFF;
                end
                2:
                begin
                    limit = 16'd0;
                    refl  = FIELD_W'($urandom);
                end
                3:
                begin
                    limit = 16'd1;
                    refl  = 16'd0;
                end
                4:
                begin
                    limit = FIELD_W'($urandom);
                    refl  = FIELD_W'($urandom);
                end
                default:
                begin
                    limit = 16'd4000;
                    refl  = 16'd300;
                end
            endcase
            apply_limits(limit, refl);
            set_idle_mode(p / 2);
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                w = random_word();
                send_word(w, 1'b0, 1'b0, typed_exp);
            end
        end

        // drain and let stragglers show up
        in_ch.valid <= 1'b0;
        while (pending_sightings.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 20) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/brb_pkg.sv
hw/rtl/brb_if.sv
hw/rtl/brb_front.sv
hw/rtl/brb_cordic.sv
hw/rtl/brb_div.sv
hw/rtl/brb_sqrt.sv
hw/rtl/beacon_range_bearing.sv
test/tb_top.sv
